>>> src/m3inv_pkg.sv
// Package for the 3x3 matrix inverse: widths, adjugate index tables and
// the divider result type. Depends on nothing; every module imports it.
package m3inv_pkg;

  localparam int DATA_W  = 32;   // element width, signed fixed point
  localparam int ELEM_N  = 9;    // elements of one matrix
  localparam int ADJ_W   = 65;   // exact adjugate element (difference of 64-bit products)
  localparam int DET_W   = 99;   // exact determinant
  localparam int QUO_W   = 32;   // quotient bits produced by the divider steps
  localparam int REM_W   = DET_W + QUO_W + 1;  // divider remainder width
  localparam int DIV_LAT = QUO_W + 2;          // divider register stages while enabled
  localparam int FRONT_N = 5;    // stages ahead of the divider

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  // adj[k] = a[ADJ_P1[k]] * a[ADJ_P2[k]] - a[ADJ_M1[k]] * a[ADJ_M2[k]]
  localparam int ADJ_P1 [ELEM_N] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_P2 [ELEM_N] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_M1 [ELEM_N] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_M2 [ELEM_N] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // The determinant is row one times the first column of the adjugate.
  localparam int DET_COL [3] = '{0, 3, 6};

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] value;
  } div_res_t;

endpackage

>>> src/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse: adjugate, determinant,
// nine pipelined dividers and an output skid stage. Uses m3inv_pkg, m3inv_div.
//
//  Port group    Direction  Carries
//  s_axis_*      in         one matrix item, a11..a33 in tdata
//  m_axis_*      out        one inverse item, r11..r33 in tdata, flags in tuser
//
// Every item passes FRONT_N + DIV_LAT + 1 = 40 register stages on its way to
// the output register; one item is accepted per cycle while the skid register
// is empty. That stage count is set by the 32 one-bit steps of the
// restoring dividers plus the multiply, adjugate, determinant and magnitude
// stages ahead of them.
// Reset clears the valid bits and the skid stage; data registers keep their
// contents. A stall at the output fills the skid register, and only then is
// s_axis_tready dropped, so the whole pipeline freezes without losing items.
module matrix3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // a11, a12, a13, a21, a22, a23, a31, a32, a33 (32 bits each, from bit 0 up)
  input  logic [m3inv_pkg::ELEM_N*m3inv_pkg::DATA_W-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33 (32 bits each, from bit 0 up)
  output logic [m3inv_pkg::ELEM_N*m3inv_pkg::DATA_W-1:0] m_axis_tdata,
  // bit 0 singular, bit 1 overflow
  output logic [1:0]                        m_axis_tuser
);
  import m3inv_pkg::*;

  localparam int OUT_W = ELEM_N * DATA_W;

  // One enable freezes every stage ahead of the output register; it is low only while the skid holds an item.
  logic en;
  logic skid_v_q, out_v_q;
  logic [FRONT_N-1:0] v_q;
  logic vd_q [DIV_LAT];
  logic sd_q [DIV_LAT];

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // Stage A: the eighteen 32x32 products of the adjugate.
  logic signed [DATA_W-1:0]   a_in   [ELEM_N];
  logic signed [2*DATA_W-1:0] pp_q   [ELEM_N];
  logic signed [2*DATA_W-1:0] pm_q   [ELEM_N];
  logic signed [DATA_W-1:0]   row_a_q [3];
  logic signed [DATA_W-1:0]   row_b_q [3];

  for (genvar k = 0; k < ELEM_N; k++) begin : g_in
    assign a_in[k] = s_axis_tdata[k*DATA_W +: DATA_W];
  end

  for (genvar k = 0; k < ELEM_N; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en) begin
        pp_q[k] <= a_in[ADJ_P1[k]] * a_in[ADJ_P2[k]];
        pm_q[k] <= a_in[ADJ_M1[k]] * a_in[ADJ_M2[k]];
      end
    end
  end

  // Stage B: exact adjugate elements.
  logic signed [ADJ_W-1:0] adj_b_q [ELEM_N];
  logic signed [ADJ_W-1:0] adj_c_q [ELEM_N];
  logic signed [ADJ_W-1:0] adj_d_q [ELEM_N];

  for (genvar k = 0; k < ELEM_N; k++) begin : g_adj
    always_ff @(posedge clk_i) begin
      if (en) begin
        adj_b_q[k] <= ADJ_W'(pp_q[k]) - ADJ_W'(pm_q[k]);
        adj_c_q[k] <= adj_b_q[k];
        adj_d_q[k] <= adj_c_q[k];
      end
    end
  end

  // Stage C: determinant partial products, each adjugate element split into a
  // low unsigned half and a high signed half so no multiplier exceeds 33 bits.
  // The first row is delayed two stages so it meets its own adjugate.
  logic signed [ADJ_W-1:0] lo_q [3];
  logic signed [ADJ_W-1:0] hi_q [3];

  for (genvar j = 0; j < 3; j++) begin : g_detp
    logic signed [DATA_W:0] adj_lo;
    logic signed [DATA_W:0] adj_hi;
    assign adj_lo = $signed({1'b0, adj_b_q[DET_COL[j]][DATA_W-1:0]});
    assign adj_hi = adj_b_q[DET_COL[j]][ADJ_W-1:DATA_W];
    always_ff @(posedge clk_i) begin
      if (en) begin
        row_a_q[j] <= a_in[j];
        row_b_q[j] <= row_a_q[j];
        lo_q[j]    <= row_b_q[j] * adj_lo;
        hi_q[j]    <= row_b_q[j] * adj_hi;
      end
    end
  end

  // Stage D: the determinant.
  logic signed [DET_W-1:0] det_d, det_q;
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DET_W'(hi_q[j]) <<< DATA_W) + DET_W'(lo_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= det_d;
    end
  end

  // Stage E: magnitudes and result signs for the dividers.
  logic [DET_W-1:0] dmag_q;
  logic             sing_q;
  logic [REM_W-1:0] nmag_q [ELEM_N];
  logic             neg_q  [ELEM_N];
  div_res_t         res    [ELEM_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      sing_q <= (det_q == '0);
    end
  end

  for (genvar k = 0; k < ELEM_N; k++) begin : g_div
    logic [ADJ_W-1:0] amag;
    assign amag = adj_d_q[k][ADJ_W-1] ? ADJ_W'(-adj_d_q[k]) : ADJ_W'(adj_d_q[k]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        nmag_q[k] <= REM_W'(amag) << (2 * FRAC_BITS);
        neg_q[k]  <= adj_d_q[k][ADJ_W-1] ^ det_q[DET_W-1];
      end
    end
    m3inv_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nmag_q[k]),
      .den_i (dmag_q),
      .neg_i (neg_q[k]),
      .res_o (res[k])
    );
  end

  // Valid bits of the front stages and the singular flag beside the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (en) begin
      v_q     <= {v_q[FRONT_N-2:0], s_axis_tvalid};
      vd_q[0] <= v_q[FRONT_N-1];
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sing_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // Assembly of the finished item.
  logic [OUT_W-1:0] data_d, out_data_q, skid_data_q;
  logic [1:0]       user_d, out_user_q, skid_user_q;
  logic             ovf_any;
  logic             last_v;
  logic             out_fire;

  always_comb begin
    ovf_any = 1'b0;
    for (int k = 0; k < ELEM_N; k++) begin
      data_d[k*DATA_W +: DATA_W] = res[k].value;
      ovf_any = ovf_any | res[k].ovf;
    end
    if (sd_q[DIV_LAT-1]) begin
      data_d = '0;
      user_d = 2'b01;
    end else begin
      user_d = {ovf_any, 1'b0};
    end
  end

  assign last_v   = vd_q[DIV_LAT-1];
  assign out_fire = out_v_q && m_axis_tready;

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (last_v) begin
      if (out_v_q && !m_axis_tready) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (last_v) begin
      if (out_v_q && !m_axis_tready) begin
        skid_data_q <= data_d;
        skid_user_q <= user_d;
      end else begin
        out_data_q <= data_d;
        out_user_q <= user_d;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The skid register only fills behind a held output item.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds an item while output is empty");

  // A singular result never reports overflow and carries an all-zero matrix.
  a_singular_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_user_q[0]) |-> (!out_user_q[1] && out_data_q == '0))
    else $error("singular result with overflow or nonzero data");

  // A waiting result is still there in the next cycle.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> out_v_q) else $error("waiting result dropped");

  // While the skid is full the pipeline is frozen, so no item enters.
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !s_axis_tready) else $error("item accepted while frozen");

endmodule

>>> src/m3inv_div.sv
// Pipelined restoring divider for one inverse element: one quotient bit per
// stage, then truncation toward zero and saturation. Uses m3inv_pkg.
module m3inv_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [m3inv_pkg::REM_W-1:0] num_i,
  input  logic [m3inv_pkg::DET_W-1:0] den_i,
  input  logic                        neg_i,
  output m3inv_pkg::div_res_t         res_o
);
  import m3inv_pkg::*;

  logic [REM_W-1:0] rem_q [QUO_W+1];
  logic [DET_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             big_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic [REM_W-1:0] den_top;
  div_res_t         res_d, res_q;

  // Quotients of 2^32 or more saturate whatever the sign.
  assign den_top = REM_W'(den_i) << QUO_W;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      big_q[0] <= (num_i >= den_top);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_step
    localparam int K = QUO_W - i;
    logic [REM_W-1:0] shifted;
    logic             ge;
    assign shifted = REM_W'(den_q[i-1]) << K;
    assign ge      = (rem_q[i-1] >= shifted);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? rem_q[i-1] - shifted : rem_q[i-1];
        den_q[i] <= den_q[i-1];
        quo_q[i] <= quo_q[i-1] | (QUO_W'(ge) << K);
        big_q[i] <= big_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  always_comb begin
    res_d.ovf   = 1'b0;
    res_d.value = quo_q[QUO_W];
    if (big_q[QUO_W]) begin
      res_d.ovf   = 1'b1;
      res_d.value = neg_q[QUO_W] ? SAT_NEG : SAT_POS;
    end else if (!neg_q[QUO_W]) begin
      if (quo_q[QUO_W] > SAT_POS) begin
        res_d.ovf   = 1'b1;
        res_d.value = SAT_POS;
      end
    end else if (quo_q[QUO_W] > SAT_NEG) begin
      res_d.ovf   = 1'b1;
      res_d.value = SAT_NEG;
    end else begin
      res_d.value = DATA_W'(0) - quo_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
